// ----- sv/lgf_pkg.sv -----
// ----------------------------------------------------------------------------
// lgf_pkg
// shared types, constants, microcode program and lookup tables for the
// led grid frame formatter
// ----------------------------------------------------------------------------
package lgf_pkg;

   localparam int GRID_COUNT = 16;
   localparam int GRID_W     = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;
   localparam int BRIGHT_W   = 3;
   localparam int STEP_W     = 2;

   localparam logic [GRID_W-1:0] GRID_LAST = GRID_W'(GRID_COUNT - 1);

   localparam logic [7:0] CMD_DATA = 8'h40;
   localparam logic [7:0] CMD_ADDR = 8'hC0;
   localparam logic [4:0] CMD_CTRL_HI = 5'b10001;

   localparam logic [7:0] VAL_DASH  = 8'hFF;
   localparam logic [7:0] VAL_UNDER = 8'hEE;

   localparam logic [3:0] CODE_DASH  = 4'd10;
   localparam logic [3:0] CODE_UNDER = 4'd11;
   localparam logic [3:0] CODE_BLANK = 4'd12;

   // source of the byte a microcode step puts out
   typedef enum logic [1:0] {
      SEL_DATA = 2'd0,
      SEL_ADDR = 2'd1,
      SEL_GRID = 2'd2,
      SEL_CTRL = 2'd3
   } byte_sel_type;

   // how a grid position takes its digit from an input slot
   typedef enum logic [1:0] {
      ROLE_TENS   = 2'd0,
      ROLE_ONES   = 2'd1,
      ROLE_SINGLE = 2'd2,
      ROLE_BLANK  = 2'd3
   } grid_role_type;

   typedef struct packed {
      logic [2:0]    slot;
      grid_role_type role;
   } grid_map_type;

   // one microcode control word
   typedef struct packed {
      byte_sel_type sel;
      logic         start_before;
      logic         stop_after;
      logic         stop_on_grid_last;
      logic         last;
      logic         loop_grid;
      logic         done;
   } ctrl_word_type;

   // sequencer to datapath control bundle
   typedef struct packed {
      logic              emit;
      byte_sel_type      sel;
      logic              start_before;
      logic              stop_after;
      logic              last;
      logic [GRID_W-1:0] grid;
   } seq_ctrl_type;

   localparam logic [STEP_W-1:0] STEP_DATA = 2'd0;
   localparam logic [STEP_W-1:0] STEP_ADDR = 2'd1;
   localparam logic [STEP_W-1:0] STEP_GRID = 2'd2;
   localparam logic [STEP_W-1:0] STEP_CTRL = 2'd3;

   // frame program
   function automatic ctrl_word_type mc_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{sel: SEL_DATA, default: 1'b0};
      unique case (step)
         STEP_DATA: begin
            w.sel          = SEL_DATA;
            w.start_before = 1'b1;
            w.stop_after   = 1'b1;
         end
         STEP_ADDR: begin
            w.sel          = SEL_ADDR;
            w.start_before = 1'b1;
         end
         STEP_GRID: begin
            w.sel               = SEL_GRID;
            w.stop_on_grid_last = 1'b1;
            w.loop_grid         = 1'b1;
         end
         STEP_CTRL: begin
            w.sel          = SEL_CTRL;
            w.start_before = 1'b1;
            w.stop_after   = 1'b1;
            w.last         = 1'b1;
            w.done         = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

   // grid position to input slot
   function automatic grid_map_type grid_map(input logic [3:0] grid);
      grid_map_type m;
      m.slot = 3'd0;
      m.role = ROLE_BLANK;
      if (grid < 4'd6) begin
         m.slot = grid[3:1];
         m.role = grid[0] ? ROLE_ONES : ROLE_TENS;
      end else if (grid == 4'd6) begin
         m.slot = 3'd3;
         m.role = ROLE_SINGLE;
      end else if (grid < 4'd15) begin
         m.slot = 3'((grid + 4'd1) >> 1);
         m.role = grid[0] ? ROLE_TENS : ROLE_ONES;
      end
      return m;
   endfunction

   function automatic logic [7:0] seg_of(input logic [3:0] code);
      logic [7:0] s;
      case (code)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         4'd10:   s = 8'h40;
         4'd11:   s = 8'h08;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

// ----- sv/lgf_req_if.sv -----
// ----------------------------------------------------------------------------
// lgf_req_if
// display update channel: eight slot values per transaction
// ----------------------------------------------------------------------------
interface lgf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pair_zero;
   logic [7:0] pair_one;
   logic [7:0] pair_two;
   logic [7:0] single_digit;
   logic [7:0] pair_four;
   logic [7:0] pair_five;
   logic [7:0] pair_six;
   logic [7:0] pair_seven;

   modport source (
      output valid, pair_zero, pair_one, pair_two, single_digit,
             pair_four, pair_five, pair_six, pair_seven,
      input  ready
   );
   modport sink (
      input  valid, pair_zero, pair_one, pair_two, single_digit,
             pair_four, pair_five, pair_six, pair_seven,
      output ready
   );
endinterface

// ----- sv/lgf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lgf_rsp_if
// driver byte channel: one frame byte with its marks per transaction
// ----------------------------------------------------------------------------
interface lgf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       start_before;
   logic       stop_after;
   logic       last;

   modport source (
      output valid, tx_byte, start_before, stop_after, last,
      input  ready
   );
   modport sink (
      input  valid, tx_byte, start_before, stop_after, last,
      output ready
   );
endinterface

// ----- sv/led_grid_frame_formatter_serializer.sv -----
// first byte: the update sets the sequencer busy register, then the data command
//   byte is loaded into the output register; throughput: 3 + GRID_COUNT bytes per
//   update, one per cycle while the output slot is free; the next update is taken
//   the cycle after the display-control byte leaves the sequencer
// reset: synchronous active high; clears sequencer and output valid,
//   brightness returns to 2
// ----------------------------------------------------------------------------
// led_grid_frame_formatter_serializer
// turns one display update into the led driver's byte frame: data command,
// address command with segment bytes, display-control command
// ----------------------------------------------------------------------------
module led_grid_frame_formatter_serializer (
   input  logic                         clock,
   input  logic                         reset,
   lgf_req_if.sink                      req_chan,
   lgf_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [lgf_pkg::BRIGHT_W-1:0] csr_wdata
);
   import lgf_pkg::*;

   logic         busy;
   logic         accept;
   logic         out_free;
   seq_ctrl_type ctrl;
   logic [7:0]   slot_value [8];

   // one update at a time; the output register decouples the last byte
   assign req_chan.ready = !busy;
   assign accept         = req_chan.valid && !busy;

   // slot order follows the grid order on the display
   assign slot_value[0] = req_chan.pair_zero;
   assign slot_value[1] = req_chan.pair_one;
   assign slot_value[2] = req_chan.pair_two;
   assign slot_value[3] = req_chan.single_digit;
   assign slot_value[4] = req_chan.pair_four;
   assign slot_value[5] = req_chan.pair_five;
   assign slot_value[6] = req_chan.pair_six;
   assign slot_value[7] = req_chan.pair_seven;

   // program rom and step counter; steps only when the output slot is free
   lgf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .out_free (out_free),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   // digit conversion and byte formatting driven by the control word
   lgf_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .slot_value (slot_value),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .ctrl       (ctrl),
      .out_ready  (rsp_chan.ready),
      .out_free   (out_free),
      .out_valid  (rsp_chan.valid),
      .out_byte   (rsp_chan.tx_byte),
      .out_start  (rsp_chan.start_before),
      .out_stop   (rsp_chan.stop_after),
      .out_last   (rsp_chan.last)
   );
endmodule

// ----- sv/lgf_seq.sv -----
// ----------------------------------------------------------------------------
// lgf_seq
// microcode sequencer: step counter, grid loop counter, program rom
// ----------------------------------------------------------------------------
module lgf_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 out_free,
   output logic                 busy,
   output lgf_pkg::seq_ctrl_type ctrl
);
   import lgf_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [GRID_W-1:0] grid_ff, grid_in;
   ctrl_word_type     cw;
   logic              grid_last;
   logic              advance;

   assign cw        = mc_word(step_ff);
   assign grid_last = (grid_ff == GRID_LAST);
   assign advance   = busy_ff && out_free;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      grid_in = grid_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = STEP_DATA;
            grid_in = '0;
         end
      end else if (advance) begin
         if (cw.loop_grid && !grid_last) begin
            grid_in = grid_ff + GRID_W'(1);
         end else begin
            grid_in = '0;
            step_in = step_ff + STEP_W'(1);
            if (cw.done) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_DATA;
         grid_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         grid_ff <= grid_in;
      end
   end

   assign busy              = busy_ff;
   assign ctrl.emit         = advance;
   assign ctrl.sel          = cw.sel;
   assign ctrl.start_before = cw.start_before;
   assign ctrl.stop_after   = cw.stop_after || (cw.stop_on_grid_last && grid_last);
   assign ctrl.last         = cw.last;
   assign ctrl.grid         = grid_ff;
endmodule

// ----- sv/lgf_datapath.sv -----
// ----------------------------------------------------------------------------
// lgf_datapath
// slot register, digit split, segment lookup, byte mux and output register
// ----------------------------------------------------------------------------
module lgf_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [7:0]             slot_value [8],
   input  logic                   csr_we,
   input  logic [lgf_pkg::BRIGHT_W-1:0] csr_wdata,
   input  lgf_pkg::seq_ctrl_type  ctrl,
   input  logic                   out_ready,
   output logic                   out_free,
   output logic                   out_valid,
   output logic [7:0]             out_byte,
   output logic                   out_start,
   output logic                   out_stop,
   output logic                   out_last
);
   import lgf_pkg::*;

   logic [7:0]          slot_ff [8];
   logic [BRIGHT_W-1:0] bright_ff;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                start_ff, stop_ff, last_ff;

   grid_map_type        gmap;
   logic [7:0]          v;
   logic [15:0]         prod;
   logic [4:0]          tens;
   logic [7:0]          tens_x10;
   logic [3:0]          ones;
   logic [3:0]          code;

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= slot_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BRIGHT_W'(2);
      end else if (csr_we) begin
         bright_ff <= csr_wdata;
      end
   end

   // divide by ten via reciprocal, exact for 8-bit values
   assign gmap     = grid_map(4'(ctrl.grid));
   assign v        = slot_ff[gmap.slot];
   assign prod     = 16'(v) * 16'd205;
   assign tens     = prod[15:11];
   assign tens_x10 = {tens[4:0], 3'b000} + {2'b00, tens[4:0], 1'b0};
   assign ones     = 4'(v - tens_x10);

   always_comb begin
      code = CODE_BLANK;
      case (gmap.role) inside
         ROLE_TENS, ROLE_ONES: begin
            if (v == VAL_DASH) begin
               code = CODE_DASH;
            end else if (v == VAL_UNDER) begin
               code = CODE_UNDER;
            end else if (gmap.role == ROLE_ONES) begin
               code = ones;
            end else if (tens > 5'd9) begin
               code = CODE_DASH;
            end else begin
               code = tens[3:0];
            end
         end
         ROLE_SINGLE: begin
            if (v == VAL_DASH) begin
               code = CODE_DASH;
            end else if (v == VAL_UNDER) begin
               code = CODE_UNDER;
            end else if (v == 8'd7) begin
               code = 4'd8;
            end else if (v > 8'd9) begin
               code = CODE_DASH;
            end else begin
               code = v[3:0];
            end
         end
         default: begin
            code = CODE_BLANK;
         end
      endcase
   end

   always_comb begin
      unique case (ctrl.sel)
         SEL_DATA: byte_in = CMD_DATA;
         SEL_ADDR: byte_in = CMD_ADDR;
         SEL_GRID: byte_in = seg_of(code);
         SEL_CTRL: byte_in = {CMD_CTRL_HI, bright_ff};
         default:  byte_in = 8'h00;
      endcase
   end

   assign out_free = !valid_ff || out_ready;
   assign valid_in = ctrl.emit || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         byte_ff  <= byte_in;
         start_ff <= ctrl.start_before;
         stop_ff  <= ctrl.stop_after;
         last_ff  <= ctrl.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_start = start_ff;
   assign out_stop  = stop_ff;
   assign out_last  = last_ff;
endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for led_grid_frame_formatter_serializer: drives display
// updates from a stimulus table and then random ones, predicts every driver
// frame byte with its start, stop and last marks, and compares the byte
// stream in order under several idle, stall and brightness settings
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRIDS        = lgf_pkg::GRID_COUNT;
   localparam int FRAME_LEN    = GRIDS + 3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int SETTLE       = 4;
   localparam int PHASE_ITEMS  = 103;

   // raw slot values with a meaning of their own
   localparam logic [7:0] KEY_DASH  = 8'hFF;
   localparam logic [7:0] KEY_UNDER = 8'hEE;

   // digit codes held per grid
   localparam logic [3:0] DIGIT_DASH  = 4'd10;
   localparam logic [3:0] DIGIT_UNDER = 4'd11;
   localparam logic [3:0] DIGIT_BLANK = 4'd12;

   // driver commands
   localparam logic [7:0] OP_DATA_CMD  = 8'h40;
   localparam logic [7:0] OP_ADDR_CMD  = 8'hC0;
   localparam logic [7:0] OP_CTRL_BASE = 8'h88;
   localparam logic [2:0] BRIGHT_RESET = 3'd2;

   // segment patterns indexed by digit code, codes above underscore are dark
   localparam logic [7:0] SEGMENTS [16] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
      8'h7F, 8'h6F, 8'h40, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      logic [7:0] pair_zero;
      logic [7:0] pair_one;
      logic [7:0] pair_two;
      logic [7:0] single_digit;
      logic [7:0] pair_four;
      logic [7:0] pair_five;
      logic [7:0] pair_six;
      logic [7:0] pair_seven;
   } display_update_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       start_before;
      logic       stop_after;
      logic       last;
   } frame_byte_type;

   // one row of the directed table; where known is set, the first two grid
   // bytes and the display-control byte are typed in by hand
   typedef struct packed {
      display_update_type upd;
      logic               known;
      logic [7:0]         grid0_seg;
      logic [7:0]         grid1_seg;
      logic [7:0]         ctrl_byte;
   } update_row_type;

   localparam int DIRECTED_ROWS = 18;
   localparam update_row_type DIRECTED [DIRECTED_ROWS] = '{
      // all zeros right after reset: brightness still at its reset value
      '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        1'b1, 8'h3F, 8'h3F, 8'h8A},
      // dash code everywhere
      '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        1'b1, 8'h40, 8'h40, 8'h8A},
      // underscore code everywhere
      '{'{8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE},
        1'b1, 8'h08, 8'h08, 8'h8A},
      // largest two-digit value, single slot far out of range
      '{'{8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99},
        1'b1, 8'h6F, 8'h6F, 8'h8A},
      // tens above nine: dash in the tens digit, ones digit still shown
      '{'{8'd253, 8'd100, 8'd199, 8'd10, 8'd200, 8'd150, 8'd101, 8'd252},
        1'b1, 8'h40, 8'h4F, 8'h8A},
      '{'{8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254},
        1'b1, 8'h40, 8'h66, 8'h8A},
      '{'{8'd100, 8'd237, 8'd239, 8'd9, 8'd238, 8'd240, 8'd255, 8'd238},
        1'b1, 8'h40, 8'h3F, 8'h8A},
      // seven in the single slot shows as eight
      '{'{8'd77, 8'd7, 8'd70, 8'd7, 8'd17, 8'd71, 8'd27, 8'd7},
        1'b0, 8'h00, 8'h00, 8'h00},
      // every digit somewhere on the grid
      '{'{8'd12, 8'd34, 8'd56, 8'd5, 8'd78, 8'd90, 8'd1, 8'd23},
        1'b0, 8'h00, 8'h00, 8'h00},
      '{'{8'd45, 8'd67, 8'd89, 8'd0, 8'd98, 8'd76, 8'd54, 8'd32},
        1'b0, 8'h00, 8'h00, 8'h00},
      // single slot just above nine and at the top of its range
      '{'{8'd1, 8'd2, 8'd3, 8'd10, 8'd4, 8'd5, 8'd6, 8'd8},
        1'b0, 8'h00, 8'h00, 8'h00},
      '{'{8'd9, 8'd19, 8'd29, 8'd254, 8'd39, 8'd49, 8'd59, 8'd69},
        1'b0, 8'h00, 8'h00, 8'h00},
      '{'{8'd0, 8'd99, 8'd0, 8'd9, 8'd99, 8'd0, 8'd99, 8'd0},
        1'b0, 8'h00, 8'h00, 8'h00},
      // codes mixed with plain values and near-miss neighbors of the codes
      '{'{8'hFF, 8'd42, 8'hEE, 8'hFF, 8'hED, 8'hEF, 8'hFE, 8'hEE},
        1'b0, 8'h00, 8'h00, 8'h00},
      '{'{8'hEE, 8'hFF, 8'd61, 8'hEE, 8'hFF, 8'd83, 8'hEE, 8'hFF},
        1'b0, 8'h00, 8'h00, 8'h00},
      // single bits walking through the fields, then alternating bit patterns
      '{'{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80},
        1'b0, 8'h00, 8'h00, 8'h00},
      '{'{8'h80, 8'h40, 8'h20, 8'h01, 8'h08, 8'h04, 8'h02, 8'h01},
        1'b0, 8'h00, 8'h00, 8'h00},
      '{'{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55},
        1'b0, 8'h00, 8'h00, 8'h00}
   };

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_we;
   logic [lgf_pkg::BRIGHT_W-1:0] csr_wdata;

   lgf_req_if req_chan ();
   lgf_rsp_if rsp_chan ();

   led_grid_frame_formatter_serializer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // bytes still owed by the block, oldest first
   frame_byte_type pending_bytes [$];
   logic [2:0]     bright_setting;
   int             send_idle_pct;
   int             rsp_stall_pct;
   int             fail_count;
   int             cycle_count;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // frame prediction
   // ---------------------------------------------------------------------

   function automatic logic [3:0] digit_or_dash(input int unsigned d);
      return (d > 9) ? DIGIT_DASH : 4'(d);
   endfunction

   // builds the whole frame of one update and queues it
   function automatic void predict_frame(input display_update_type u);
      logic [7:0]     slot_val [8];
      logic [3:0]     grid_code [16];
      int unsigned    pos;
      frame_byte_type fb;
      slot_val = '{u.pair_zero, u.pair_one, u.pair_two, u.single_digit,
                   u.pair_four, u.pair_five, u.pair_six, u.pair_seven};
      for (int s = 0; s < 8; s++) begin
         pos = (s <= 3) ? 2 * s : 2 * s - 1;
         if (s == 3) begin
            // lone digit: seven is drawn as eight
            if (slot_val[s] == KEY_DASH)
               grid_code[pos] = DIGIT_DASH;
            else if (slot_val[s] == KEY_UNDER)
               grid_code[pos] = DIGIT_UNDER;
            else if (slot_val[s] == 8'd7)
               grid_code[pos] = 4'd8;
            else
               grid_code[pos] = digit_or_dash(slot_val[s]);
         end else if (slot_val[s] == KEY_DASH) begin
            grid_code[pos]     = DIGIT_DASH;
            grid_code[pos + 1] = DIGIT_DASH;
         end else if (slot_val[s] == KEY_UNDER) begin
            grid_code[pos]     = DIGIT_UNDER;
            grid_code[pos + 1] = DIGIT_UNDER;
         end else begin
            grid_code[pos]     = digit_or_dash(slot_val[s] / 10);
            grid_code[pos + 1] = digit_or_dash(slot_val[s] % 10);
         end
      end
      grid_code[15] = DIGIT_BLANK;

      pending_bytes.push_back('{OP_DATA_CMD, 1'b1, 1'b1, 1'b0});
      pending_bytes.push_back('{OP_ADDR_CMD, 1'b1, 1'b0, 1'b0});
      for (int g = 0; g < GRIDS && g < 16; g++) begin
         fb.tx_byte      = SEGMENTS[grid_code[g]];
         fb.start_before = 1'b0;
         fb.stop_after   = (g == GRIDS - 1) || (g == 15);
         fb.last         = 1'b0;
         pending_bytes.push_back(fb);
      end
      pending_bytes.push_back('{OP_CTRL_BASE | {5'd0, bright_setting}, 1'b1, 1'b1, 1'b1});
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // slot value biased toward the interesting classes
   function automatic logic [7:0] pick_slot_value(input bit lone);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return KEY_DASH;
      if (roll < 20)
         return KEY_UNDER;
      if (roll < 50)
         return 8'($urandom_range(lone ? 9 : 99));
      if (roll < 65)
         return 8'($urandom_range(253, lone ? 10 : 100));
      return 8'($urandom);
   endfunction

   function automatic display_update_type pick_update();
      display_update_type u;
      u.pair_zero    = pick_slot_value(1'b0);
      u.pair_one     = pick_slot_value(1'b0);
      u.pair_two     = pick_slot_value(1'b0);
      u.single_digit = pick_slot_value(1'b1);
      u.pair_four    = pick_slot_value(1'b0);
      u.pair_five    = pick_slot_value(1'b0);
      u.pair_six     = pick_slot_value(1'b0);
      u.pair_seven   = pick_slot_value(1'b0);
      return u;
   endfunction

   // one update transaction, with random idle cycles ahead of it;
   // a typed row overrides the predicted bytes it pins down
   task automatic send_update(input update_row_type row);
      int base;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.pair_zero    <= row.upd.pair_zero;
      req_chan.pair_one     <= row.upd.pair_one;
      req_chan.pair_two     <= row.upd.pair_two;
      req_chan.single_digit <= row.upd.single_digit;
      req_chan.pair_four    <= row.upd.pair_four;
      req_chan.pair_five    <= row.upd.pair_five;
      req_chan.pair_six     <= row.upd.pair_six;
      req_chan.pair_seven   <= row.upd.pair_seven;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predict_frame(row.upd);
      if (row.known) begin
         base = pending_bytes.size() - FRAME_LEN;
         pending_bytes[base + 2].tx_byte             = row.grid0_seg;
         pending_bytes[base + 3].tx_byte             = row.grid1_seg;
         pending_bytes[base + FRAME_LEN - 1].tx_byte = row.ctrl_byte;
      end
   endtask

   // hold the sender off until every owed byte has come out
   task automatic drain_frames();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_bytes.size() != 0)
         @(negedge clock);
   endtask

   // register write, only while the block is idle
   task automatic set_brightness(input logic [2:0] level);
      drain_frames();
      repeat (SETTLE) @(negedge clock);
      csr_we         <= 1'b1;
      csr_wdata      <= level;
      bright_setting  = level;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input int idle_pct, input int stall_pct, input bit hold_off);
      update_row_type row;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         // occasional full drain so a fresh frame starts on an empty pipe
         if ((hold_off && k == PHASE_ITEMS / 2) || $urandom_range(39) == 0)
            drain_frames();
         row = '0;
         row.upd = pick_update();
         send_update(row);
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver: random stalls at the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------------
   // byte checker: each accepted frame byte against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            $error("frame byte 0x%02h with nothing owed", rsp_chan.tx_byte);
            fail_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_chan.tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, rsp_chan.tx_byte);
               fail_count++;
            end
            if (rsp_chan.start_before !== want.start_before) begin
               $error("start_before: expected %0b, got %0b",
                      want.start_before, rsp_chan.start_before);
               fail_count++;
            end
            if (rsp_chan.stop_after !== want.stop_after) begin
               $error("stop_after: expected %0b, got %0b",
                      want.stop_after, rsp_chan.stop_after);
               fail_count++;
            end
            if (rsp_chan.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_chan.last);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.pair_zero    = '0;
      req_chan.pair_one     = '0;
      req_chan.pair_two     = '0;
      req_chan.single_digit = '0;
      req_chan.pair_four    = '0;
      req_chan.pair_five    = '0;
      req_chan.pair_six     = '0;
      req_chan.pair_seven   = '0;
      rsp_chan.ready        = 1'b0;
      bright_setting        = BRIGHT_RESET;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;
      fail_count            = 0;
      cycle_count           = 0;

      // reset held from the start, then released at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at full rate and reset brightness
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_update(DIRECTED[r]);

      // dimmest setting, sparse sender
      set_brightness(3'd0);
      run_random(81, 0, 1'b0);

      // brightest setting, receiver mostly stalled
      set_brightness(3'd7);
      run_random(0, 81, 1'b0);

      // mid setting, both sides idle now and then, one forced drain
      set_brightness(3'($urandom_range(6, 1)));
      run_random(30, 30, 1'b1);

      // random setting, back to back
      set_brightness(3'($urandom_range(7)));
      run_random(0, 0, 1'b0);

      // let the last frame out, then watch for stray bytes
      drain_frames();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_bytes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
